// ===== rtl/cts_pkg.sv =====
// shared types, constants and character classifier for the calculator token scanner
`timescale 1ns / 1ps
`default_nettype none
package cts_pkg;

	// token buffer sizing
	localparam int TOKEN_CAPACITY = 32;
	localparam int TOKEN_DEPTH    = TOKEN_CAPACITY - 1;
	localparam int CNT_W          = $clog2(TOKEN_CAPACITY);
	localparam logic [CNT_W-1:0] TOKEN_LEN_LIMIT = CNT_W'(TOKEN_CAPACITY - 1);

	// scanner states, also the token type on results
	localparam logic [1:0] TK_DEFAULT  = 2'd0;
	localparam logic [1:0] TK_NUMBER   = 2'd1;
	localparam logic [1:0] TK_OPERATOR = 2'd2;
	localparam logic [1:0] TK_KEYWORD  = 2'd3;

	// result kind codes
	localparam logic KIND_TOKEN = 1'b0;
	localparam logic KIND_ERROR = 1'b1;

	// input action codes
	localparam logic ACT_CHAR = 1'b0;
	localparam logic ACT_EOL  = 1'b1;

	// configuration register indexes
	localparam logic CFG_MASK_LO = 1'b0;
	localparam logic CFG_MASK_HI = 1'b1;

	localparam logic [63:0] MASK_LO_RESET = 64'h0000_AF20_0000_0000;
	localparam logic [63:0] MASK_HI_RESET = 64'h0000_0000_4000_0000;

	typedef struct packed {
		logic ws;
		logic bad;
		logic dig;
		logic op;
		logic alp;
	} char_flags_t;

	// token buffer write port
	typedef struct packed {
		logic             en;
		logic [CNT_W-1:0] addr;
		logic [6:0]       data;
	} buf_wr_t;

	function automatic char_flags_t char_flags(input logic [6:0] c, input logic [63:0] lo,
		input logic [63:0] hi);
		char_flags_t f;
		logic        punct;
		punct = (c == 7'h21) || (c == 7'h40) || (c == 7'h24) || (c == 7'h23) ||
			(c == 7'h3f) || (c == 7'h3a) || (c == 7'h3b) || (c == 7'h5c) ||
			(c == 7'h27) || (c == 7'h22) || (c == 7'h60) || (c == 7'h5b) ||
			(c == 7'h5d) || (c == 7'h7b) || (c == 7'h7d);
		f.ws  = (c == 7'd32) || (c >= 7'd9 && c <= 7'd13);
		f.bad = (c < 7'd32) || (c == 7'd127) || punct;
		f.dig = (c >= 7'd48) && (c <= 7'd57);
		f.alp = (c >= 7'd65 && c <= 7'd90) || (c >= 7'd97 && c <= 7'd122);
		f.op  = c[6] ? hi[c[5:0]] : lo[c[5:0]];
		return f;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/cts_token_buf.sv =====
// token character buffer with registered read
`timescale 1ns / 1ps
`default_nettype none
module cts_token_buf (
	input  wire                         clk,
	input  wire cts_pkg::buf_wr_t       wr,
	input  wire [cts_pkg::CNT_W-1:0]    rd_addr,
	output logic [6:0]                  rd_data
);

	logic [6:0] mem [cts_pkg::TOKEN_DEPTH];

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule
`default_nettype wire

// ===== rtl/calculator_token_scanner.sv =====
// top level of the calculator token scanner
//
// usage:
//   input channel (in_valid/in_ready, action, ch) takes one character or an
//   end-of-line mark per transaction; ch of zero also ends the line
//   output channel (out_valid/out_ready) gives result transactions: token
//   characters tagged with type, position and length, or one error result
//   config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the two
//   64-bit operator masks; it is always ready, write only while idle
// timing:
//   one item at a time; in_ready is high only while the sequencer idles
//   an item with no result or a single result passes through the decide
//   state only, which loads the single result into the output register
//   a token is sent one character at a time: each is read from the token
//   buffer in the read state and moved to the output register in the write
//   state; the single buffer read port and output register set this pace
// reset: arst_n clears the scanner state, token count, abort flag, output
//   valid and loads the default operator masks; no clearing pass is needed
// stall: a full output register that is not taken holds the sequencer in
//   place; nothing is dropped or repeated
`timescale 1ns / 1ps
`default_nettype none
module calculator_token_scanner (
	input  wire         clk,
	input  wire         arst_n,
	// input items
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         action,
	input  wire  [6:0]  ch,
	// results
	output logic        out_valid,
	input  wire         out_ready,
	output logic        kind,
	output logic [1:0]  token_kind,
	output logic [4:0]  position,
	output logic [6:0]  token_char,
	output logic [4:0]  token_length,
	output logic        last,
	// configuration
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire         cfg_index,
	input  wire  [63:0] cfg_data
);

	// sequencer codes
	localparam logic [1:0] SQ_IDLE   = 2'd0;
	localparam logic [1:0] SQ_DECIDE = 2'd1;
	localparam logic [1:0] SQ_RD     = 2'd2;
	localparam logic [1:0] SQ_WR     = 2'd3;

	localparam int CW = cts_pkg::CNT_W;

	logic [1:0]    seq_q;
	logic [1:0]    scan_q;
	logic [CW-1:0] count_q;
	logic          abort_q;
	logic [63:0]   mask_lo_q;
	logic [63:0]   mask_hi_q;

	// latched item
	logic          act_q;
	logic [6:0]    ch_q;

	// pending work after a token run
	logic          acc_q;
	logic [1:0]    nscan_q;
	logic [CW-1:0] idx_q;

	cts_pkg::char_flags_t flags;
	cts_pkg::buf_wr_t     wr;
	logic [6:0]           rd_data;

	// decision for the latched item
	logic       eol;
	logic       d_err;
	logic       d_emit;
	logic       d_acc;
	logic [1:0] d_scan;

	logic       out_free;
	logic       run_last;

	// output load
	logic          ld;
	logic          ld_kind;
	logic [1:0]    ld_tk;
	logic [CW-1:0] ld_pos;
	logic [6:0]    ld_char;
	logic [CW-1:0] ld_len;
	logic          ld_last;

	assign in_ready  = (seq_q == SQ_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid || out_ready;
	assign run_last  = (idx_q + CW'(1)) == count_q;

	assign flags = cts_pkg::char_flags(ch_q, mask_lo_q, mask_hi_q);
	assign eol   = (act_q == cts_pkg::ACT_EOL) || (ch_q == 7'd0);

	// class logic, ordered as the scanner rules require
	always_comb begin
		d_err  = 1'b0;
		d_emit = 1'b0;
		d_acc  = 1'b0;
		d_scan = scan_q;
		priority if (eol) begin
			d_emit = !abort_q;
			d_scan = cts_pkg::TK_DEFAULT;
		end else if (abort_q || flags.ws) begin
			d_scan = scan_q;
		end else if (flags.bad) begin
			d_err = 1'b1;
		end else begin
			unique case (scan_q)
				cts_pkg::TK_DEFAULT: begin
					d_acc = flags.dig || flags.op || flags.alp;
					priority if (flags.dig) d_scan = cts_pkg::TK_NUMBER;
					else if (flags.op)      d_scan = cts_pkg::TK_OPERATOR;
					else if (flags.alp)     d_scan = cts_pkg::TK_KEYWORD;
					else                    d_scan = scan_q;
				end
				cts_pkg::TK_NUMBER: begin
					priority if (flags.dig) begin
						d_acc = 1'b1;
					end else if (flags.op) begin
						d_emit = 1'b1;
						d_acc  = 1'b1;
						d_scan = cts_pkg::TK_OPERATOR;
					end else if (flags.alp) begin
						d_emit = 1'b1;
						d_acc  = 1'b1;
						d_scan = cts_pkg::TK_KEYWORD;
					end else begin
						d_acc = 1'b0;
					end
				end
				cts_pkg::TK_OPERATOR: begin
					// any class closes an operator token
					d_emit = 1'b1;
					d_acc  = 1'b1;
					priority if (flags.dig) d_scan = cts_pkg::TK_NUMBER;
					else if (flags.op)      d_scan = cts_pkg::TK_OPERATOR;
					else if (flags.alp)     d_scan = cts_pkg::TK_KEYWORD;
					else                    d_scan = scan_q;
				end
				cts_pkg::TK_KEYWORD: begin
					priority if (flags.dig || flags.alp) begin
						d_acc = 1'b1;
					end else if (flags.op) begin
						d_emit = 1'b1;
						d_acc  = 1'b1;
						d_scan = cts_pkg::TK_OPERATOR;
					end else begin
						d_acc = 1'b0;
					end
				end
				default: d_scan = scan_q;
			endcase
		end
	end

	// output register loads and token buffer writes
	always_comb begin
		ld      = 1'b0;
		ld_kind = cts_pkg::KIND_TOKEN;
		ld_tk   = scan_q;
		ld_pos  = '0;
		ld_char = '0;
		ld_len  = '0;
		ld_last = 1'b1;
		wr.en   = 1'b0;
		wr.addr = '0;
		wr.data = ch_q;
		unique case (seq_q)
			SQ_DECIDE: begin
				priority if (d_err) begin
					// error result: offending character, nothing else
					ld      = out_free;
					ld_kind = cts_pkg::KIND_ERROR;
					ld_tk   = cts_pkg::TK_DEFAULT;
					ld_char = ch_q;
				end else if (d_emit && count_q == '0) begin
					// empty token, then the new character starts the buffer
					ld    = out_free;
					wr.en = out_free && d_acc;
				end else if (d_emit) begin
					ld = 1'b0;
				end else begin
					wr.en   = d_acc && (count_q < cts_pkg::TOKEN_LEN_LIMIT);
					wr.addr = count_q;
				end
			end
			SQ_WR: begin
				ld      = out_free;
				ld_pos  = idx_q;
				ld_char = rd_data;
				ld_len  = count_q;
				ld_last = run_last;
				wr.en   = out_free && run_last && acc_q;
			end
			default: ld = 1'b0;
		endcase
	end

	cts_token_buf u_buf (
		.clk     (clk),
		.wr      (wr),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	// sequencer and scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q     <= SQ_IDLE;
			scan_q    <= cts_pkg::TK_DEFAULT;
			count_q   <= '0;
			abort_q   <= 1'b0;
			mask_lo_q <= cts_pkg::MASK_LO_RESET;
			mask_hi_q <= cts_pkg::MASK_HI_RESET;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					cts_pkg::CFG_MASK_LO: mask_lo_q <= cfg_data;
					cts_pkg::CFG_MASK_HI: mask_hi_q <= cfg_data;
					default:              mask_lo_q <= mask_lo_q;
				endcase
			end
			unique case (seq_q)
				SQ_IDLE: begin
					if (in_valid) begin
						seq_q <= SQ_DECIDE;
					end
				end
				SQ_DECIDE: begin
					priority if (d_err) begin
						if (out_free) begin
							count_q <= '0;
							scan_q  <= cts_pkg::TK_DEFAULT;
							abort_q <= 1'b1;
							seq_q   <= SQ_IDLE;
						end
					end else if (d_emit && count_q == '0) begin
						if (out_free) begin
							count_q <= d_acc ? CW'(1) : '0;
							scan_q  <= d_scan;
							seq_q   <= SQ_IDLE;
						end
					end else if (d_emit) begin
						seq_q <= SQ_RD;
					end else begin
						if (eol) begin
							// end of an aborted line: no result
							count_q <= '0;
							abort_q <= 1'b0;
						end else if (wr.en) begin
							count_q <= count_q + CW'(1);
						end
						scan_q <= d_scan;
						seq_q  <= SQ_IDLE;
					end
				end
				SQ_RD: begin
					seq_q <= SQ_WR;
				end
				SQ_WR: begin
					if (out_free) begin
						if (run_last) begin
							count_q <= acc_q ? CW'(1) : '0;
							scan_q  <= nscan_q;
							seq_q   <= SQ_IDLE;
						end else begin
							seq_q <= SQ_RD;
						end
					end
				end
				default: seq_q <= SQ_IDLE;
			endcase
		end
	end

	// item latch and run bookkeeping
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			act_q <= action;
			ch_q  <= ch;
		end
		if (seq_q == SQ_DECIDE) begin
			acc_q   <= d_acc;
			nscan_q <= d_scan;
			idx_q   <= '0;
		end else if (seq_q == SQ_WR && out_free && !run_last) begin
			idx_q <= idx_q + CW'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (ld) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			kind         <= ld_kind;
			token_kind   <= ld_tk;
			position     <= ld_pos;
			token_char   <= ld_char;
			token_length <= ld_len;
			last         <= ld_last;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/cts_check.sv =====
// port-level checks for the calculator token scanner, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module cts_check (
	input wire        clk,
	input wire        arst_n,
	input wire        out_valid,
	input wire        out_ready,
	input wire        kind,
	input wire [1:0]  token_kind,
	input wire [4:0]  position,
	input wire [6:0]  token_char,
	input wire [4:0]  token_length,
	input wire        last
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(token_char) && $stable(position)
			&& $stable(kind) && $stable(last))
		else $error("result changed while stalled");

	// an error result is a lone result with no token data
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cts_pkg::KIND_ERROR |-> last && position == 5'd0
			&& token_length == 5'd0 && token_kind == cts_pkg::TK_DEFAULT)
		else $error("malformed error result");

	// characters of a token stay inside its length and the last one is flagged
	a_run_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cts_pkg::KIND_TOKEN && token_length != 5'd0
			|-> position < token_length && (last == (position + 5'd1 == token_length)))
		else $error("token character out of place");

	// an empty token is one result with a zero character
	a_empty_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == cts_pkg::KIND_TOKEN && token_length == 5'd0
			|-> last && position == 5'd0 && token_char == 7'd0)
		else $error("malformed empty token");

endmodule

bind calculator_token_scanner cts_check u_cts_check (.*);
`default_nettype wire

// ===== tb/cts_scan_checker.sv =====
// checker for the calculator token scanner: watches the channels, predicts and compares results
`timescale 1ns / 1ps
module cts_scan_checker (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	input  wire         in_ready,
	input  wire         action,
	input  wire  [6:0]  ch,
	input  wire         out_valid,
	input  wire         out_ready,
	input  wire         kind,
	input  wire  [1:0]  token_kind,
	input  wire  [4:0]  position,
	input  wire  [6:0]  token_char,
	input  wire  [4:0]  token_length,
	input  wire         last,
	input  wire         cfg_valid,
	input  wire         cfg_ready,
	input  wire         cfg_index,
	input  wire  [63:0] cfg_data,
	output int          mismatches,
	output int          results_checked,
	output int          pending
);
	import cts_pkg::*;

	typedef struct packed {
		logic       kind;
		logic [1:0] tkind;
		logic [4:0] pos;
		logic [6:0] chr;
		logic [4:0] len;
		logic       lst;
	} scan_result_t;

	scan_result_t pending_results[$];

	logic [63:0] op_lo;
	logic [63:0] op_hi;
	logic [1:0]  scan_mode;
	logic [6:0]  held_chars [TOKEN_DEPTH];
	int          held_len;
	logic        line_dead;
	int          bad_count;
	int          checked;

	function automatic logic is_blank(input logic [6:0] c);
		return (c == 7'd32) || (c >= 7'd9 && c <= 7'd13);
	endfunction

	function automatic logic is_forbidden(input logic [6:0] c);
		if (c < 7'd32 || c == 7'h7f)
			return 1'b1;
		case (c)
		7'h21, 7'h22, 7'h23, 7'h24, 7'h27, 7'h3a, 7'h3b, 7'h3f, 7'h40,
		7'h5b, 7'h5c, 7'h5d, 7'h60, 7'h7b, 7'h7d: return 1'b1;
		default: return 1'b0;
		endcase
	endfunction

	task automatic push_result(input logic k, input logic [1:0] tk, input logic [4:0] p,
		input logic [6:0] c, input logic [4:0] n, input logic l);
		pending_results.push_back({k, tk, p, c, n, l});
	endtask

	// send the buffered token out, one result per character, or one empty result if none is held
	task automatic flush_token();
		if (held_len == 0)
			push_result(KIND_TOKEN, scan_mode, 5'd0, 7'd0, 5'd0, 1'b1);
		else
			for (int k = 0; k < held_len; k++)
				push_result(KIND_TOKEN, scan_mode, 5'(k), held_chars[k], 5'(held_len),
					k == held_len - 1);
		held_len = 0;
	endtask

	task automatic buffer_char(input logic [6:0] c);
		if (held_len < TOKEN_DEPTH) begin
			held_chars[held_len] = c;
			held_len++;
		end
	endtask

	task automatic scan_item(input logic a, input logic [6:0] c);
		logic dig;
		logic alp;
		logic op;
		dig = (c >= 7'd48) && (c <= 7'd57);
		alp = (c >= 7'd65 && c <= 7'd90) || (c >= 7'd97 && c <= 7'd122);
		op  = c[6] ? op_hi[c[5:0]] : op_lo[c[5:0]];
		if (a == ACT_EOL || c == 7'd0) begin
			if (line_dead)
				line_dead = 1'b0;
			else
				flush_token();
			held_len  = 0;
			scan_mode = TK_DEFAULT;
		end else if (line_dead || is_blank(c)) begin
			// nothing to do
		end else if (is_forbidden(c)) begin
			push_result(KIND_ERROR, TK_DEFAULT, 5'd0, c, 5'd0, 1'b1);
			held_len  = 0;
			scan_mode = TK_DEFAULT;
			line_dead = 1'b1;
		end else begin
			case (scan_mode)
			TK_DEFAULT: begin
				if (dig) begin
					buffer_char(c);
					scan_mode = TK_NUMBER;
				end else if (op) begin
					buffer_char(c);
					scan_mode = TK_OPERATOR;
				end else if (alp) begin
					buffer_char(c);
					scan_mode = TK_KEYWORD;
				end
			end
			TK_NUMBER: begin
				if (dig) begin
					buffer_char(c);
				end else if (op) begin
					flush_token();
					buffer_char(c);
					scan_mode = TK_OPERATOR;
				end else if (alp) begin
					flush_token();
					buffer_char(c);
					scan_mode = TK_KEYWORD;
				end
			end
			TK_OPERATOR: begin
				// operators are single characters, anything after one closes it
				flush_token();
				buffer_char(c);
				if (dig)
					scan_mode = TK_NUMBER;
				else if (op)
					scan_mode = TK_OPERATOR;
				else if (alp)
					scan_mode = TK_KEYWORD;
			end
			default: begin
				if (dig || alp) begin
					buffer_char(c);
				end else if (op) begin
					flush_token();
					buffer_char(c);
					scan_mode = TK_OPERATOR;
				end
			end
			endcase
		end
	endtask

	task automatic report_bad(input string what, input int got, input int want);
		bad_count++;
		$display("%0t: %s wrong on result %0d: got %0d, want %0d", $time, what, checked,
			got, want);
	endtask

	task automatic check_result();
		scan_result_t want;
		if (pending_results.size() == 0) begin
			report_bad("unexpected result, token_char", token_char, 0);
		end else begin
			want = pending_results.pop_front();
			if (kind !== want.kind)
				report_bad("kind", kind, want.kind);
			if (token_kind !== want.tkind)
				report_bad("token_kind", token_kind, want.tkind);
			if (position !== want.pos)
				report_bad("position", position, want.pos);
			if (token_char !== want.chr)
				report_bad("token_char", token_char, want.chr);
			if (token_length !== want.len)
				report_bad("token_length", token_length, want.len);
			if (last !== want.lst)
				report_bad("last", last, want.lst);
		end
		checked++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_results.delete();
			op_lo           = MASK_LO_RESET;
			op_hi           = MASK_HI_RESET;
			scan_mode       = TK_DEFAULT;
			held_len        = 0;
			line_dead       = 1'b0;
			bad_count       = 0;
			checked         = 0;
			mismatches      <= 0;
			results_checked <= 0;
			pending         <= 0;
		end else begin
			// results leave before the item accepted on the same edge can produce any
			if (out_valid && out_ready)
				check_result();
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_MASK_LO)
					op_lo = cfg_data;
				else
					op_hi = cfg_data;
			end
			if (in_valid && in_ready)
				scan_item(action, ch);
			mismatches      <= bad_count;
			results_checked <= checked;
			pending         <= pending_results.size();
		end
	end

endmodule

// ===== tb/calculator_token_scanner_tb.sv =====
// testbench top for the calculator token scanner: stimulus, idling and verdict
`timescale 1ns / 1ps
module calculator_token_scanner_tb;
	import cts_pkg::*;

	// settle time after the last expected result, long enough for a full token to drain
	localparam int SETTLE      = 72;
	localparam int CYCLE_LIMIT = 400000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        action    = 1'b0;
	logic [6:0]  ch        = 7'd0;
	logic        out_ready = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_index = 1'b0;
	logic [63:0] cfg_data  = 64'd0;

	wire         in_ready;
	wire         out_valid;
	wire         kind;
	wire  [1:0]  token_kind;
	wire  [4:0]  position;
	wire  [6:0]  token_char;
	wire  [4:0]  token_length;
	wire         last;
	wire         cfg_ready;

	int mismatches;
	int results_checked;
	int pending;

	// copy of the operator masks, used to pick characters the block sees as operators
	logic [63:0] mask_lo = MASK_LO_RESET;
	logic [63:0] mask_hi = MASK_HI_RESET;

	// quiet: no idling for the current line; steady: no idling for the rest of the run
	logic quiet  = 1'b0;
	logic steady = 1'b0;
	int   items_sent  = 0;
	int   stall_left  = 0;
	int   cycle_count = 0;

	always #6 clk = ~clk;

	calculator_token_scanner uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.ch           (ch),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.kind         (kind),
		.token_kind   (token_kind),
		.position     (position),
		.token_char   (token_char),
		.token_length (token_length),
		.last         (last),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	cts_scan_checker scan_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.action          (action),
		.ch              (ch),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.kind            (kind),
		.token_kind      (token_kind),
		.position        (position),
		.token_char      (token_char),
		.token_length    (token_length),
		.last            (last),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.mismatches      (mismatches),
		.results_checked (results_checked),
		.pending         (pending)
	);

	// receiver side: random stall bursts of random length, none when quiet or steady
	always @(posedge clk) begin
		if (steady || quiet) begin
			out_ready <= 1'b1;
		end else if (stall_left != 0) begin
			out_ready  <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			out_ready  <= 1'b0;
			stall_left <= $urandom_range(0, 9);
		end else begin
			out_ready <= 1'b1;
		end
	end

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected", cycle_count, pending);
			$display("Mismatches found");
			$finish;
		end
	end

	// one input transaction; may open with a sender gap of random length
	task automatic send_item(input logic a, input logic [6:0] c);
		if (!quiet && !steady && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		action   <= a;
		ch       <= c;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		items_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++)
			send_item(ACT_CHAR, 7'(s[i]));
	endtask

	// hold off until every expected result has arrived, then let the block go quiet
	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_mask(input logic idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == CFG_MASK_LO)
			mask_lo = data;
		else
			mask_hi = data;
		@(posedge clk);
	endtask

	function automatic logic [6:0] letter_char();
		if ($urandom_range(0, 1) == 0)
			return 7'(65 + $urandom_range(0, 25));
		return 7'(97 + $urandom_range(0, 25));
	endfunction

	// a character the current masks call an operator, if the pool has one
	function automatic logic [6:0] op_char();
		string      pool = "%()*+-/^&|<>=~,._";
		logic [6:0] c;
		for (int t = 0; t < 40; t++) begin
			c = 7'(pool[$urandom_range(0, pool.len() - 1)]);
			if (c[6] ? mask_hi[c[5:0]] : mask_lo[c[5:0]])
				return c;
		end
		// no operators in the pool: an unclassed character instead
		return 7'h2b;
	endfunction

	// control codes other than nul and whitespace, delete and the listed punctuation all abort the line
	function automatic logic [6:0] forbidden_char();
		case ($urandom_range(0, 17))
		0:  return 7'h21;
		1:  return 7'h40;
		2:  return 7'h24;
		3:  return 7'h23;
		4:  return 7'h3f;
		5:  return 7'h3a;
		6:  return 7'h3b;
		7:  return 7'h5c;
		8:  return 7'h27;
		9:  return 7'h22;
		10: return 7'h60;
		11: return 7'h5b;
		12: return 7'h5d;
		13: return 7'h7b;
		14: return 7'h7d;
		15: return 7'h7f;
		16: return 7'($urandom_range(1, 8));
		default: return 7'($urandom_range(14, 31));
		endcase
	endfunction

	// one line: mostly well-formed tokens, sometimes noise or a broken line
	task automatic random_line();
		int         tokens;
		int         run;
		int         cls;
		logic [6:0] c;
		quiet  <= ($urandom_range(0, 3) == 0);
		tokens = $urandom_range(1, 5);
		for (int t = 0; t < tokens; t++) begin
			cls = $urandom_range(0, 9);
			run = ($urandom_range(0, 39) == 0) ? $urandom_range(28, 36) : $urandom_range(1, 4);
			for (int i = 0; i < run; i++) begin
				if (cls <= 3)
					c = 7'(48 + $urandom_range(0, 9));
				else if (cls <= 5)
					c = op_char();
				else if (cls <= 8)
					c = letter_char();
				else
					c = 7'($urandom_range(32, 126));
				send_item(ACT_CHAR, c);
			end
			// optional whitespace between tokens
			if ($urandom_range(0, 2) == 0)
				send_item(ACT_CHAR, ($urandom_range(0, 1) == 0) ? 7'd32 :
					7'($urandom_range(9, 13)));
		end
		// broken line: an illegal character followed by a few that must be dropped
		if ($urandom_range(0, 7) == 0) begin
			send_item(ACT_CHAR, forbidden_char());
			repeat ($urandom_range(0, 3)) send_item(ACT_CHAR, 7'($urandom_range(1, 127)));
		end
		// end of line, sometimes as a nul character
		if ($urandom_range(0, 7) == 0)
			send_item(ACT_CHAR, 7'd0);
		else
			send_item(ACT_EOL, 7'($urandom_range(0, 127)));
	endtask

	// new masks while idle, then a batch of random lines under them
	task automatic run_phase(input logic [63:0] lo, input logic [63:0] hi, input int count);
		int goal;
		drain();
		write_mask(CFG_MASK_LO, lo);
		write_mask(CFG_MASK_HI, hi);
		goal = items_sent + count;
		while (items_sent < goal) random_line();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part under the reset masks
		// number, operator, keyword: each class change closes the previous token
		send_text("7+x");
		// sender holds off mid-line until everything expected has come
		drain();
		// whitespace skipped, mixed case stays keyword, unclassed underscore ignored
		send_text(" \tZz_");
		send_item(ACT_EOL, 7'h7f);
		// empty lines: end-of-line item and nul character
		send_item(ACT_EOL, 7'h00);
		send_item(ACT_CHAR, 7'h00);
		// high-half operator, then an unclassed char opening an operator-typed token
		send_text("^_9");
		send_item(ACT_EOL, 7'h55);
		// error drops the buffered digit and the rest of the line
		send_text("4!5");
		send_item(ACT_EOL, 7'h2a);
		// control code and delete both abort
		send_item(ACT_CHAR, 7'h01);
		send_item(ACT_EOL, 7'h00);
		send_item(ACT_CHAR, 7'h7f);
		send_item(ACT_CHAR, 7'h00);
		// carriage return is whitespace
		send_text("0\r");
		send_item(ACT_EOL, 7'h01);

		// keyword longer than the buffer: the tail characters are dropped
		repeat (34) send_item(ACT_CHAR, letter_char());
		send_item(ACT_EOL, 7'h00);

		// random lines under reset masks, then all-ones, all-zero and random masks
		while (items_sent < 62) random_line();
		run_phase('1, '1, 6);
		run_phase('0, '0, 6);
		run_phase({$urandom, $urandom}, {$urandom, $urandom}, 6);

		// last stretch back on the default masks with no idling at all
		steady <= 1'b1;
		run_phase(MASK_LO_RESET, MASK_HI_RESET, 8);

		drain();
		$display("sent %0d input transactions under five operator mask settings", items_sent);
		$display("checked %0d result transactions, including long tokens and aborted lines",
			results_checked);
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
